FILE: rtl/median_of_three_quicksort_assert.svh
// assertion macros for the median-of-three quicksort block
`ifndef MEDIAN_OF_THREE_QUICKSORT_ASSERT_SVH
`define MEDIAN_OF_THREE_QUICKSORT_ASSERT_SVH

// same-cycle implication, reset masks the check
`define MQS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define MQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mqs_pkg.sv
// ----------------------------------------------------------------------------
// mqs_pkg
// Shared types and constants of the median-of-three quicksort block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mqs_pkg;

	localparam int MAX_KEYS_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int THR_W         = 7;
	localparam logic [THR_W-1:0] THR_RESET = 7'd16;

	// register indexes
	localparam logic REG_THR = 1'b0;
	localparam logic REG_SGN = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_POP, S_POPW, S_CHOOSE, S_PIVMID,
		S_MRB, S_MRM, S_MRL, S_MSEL,
		S_SWPIV, S_SWLH, S_SWBH, S_SWRA, S_SWRB, S_SWWA, S_SWWB,
		S_PINIT, S_LORD, S_LOCK, S_HIRD, S_HICK,
		S_PUSHR, S_PUSHL, S_EMRD, S_EMOUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SWK_PIV, SWK_PART, SWK_FIN
	} swap_kind_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_INIT, OP_POP_RD, OP_POP_LATCH, OP_PIV_MID,
		OP_MED_RB, OP_MED_RM, OP_MED_RL, OP_MED_SEL,
		OP_SW_SET_PIV, OP_SW_SET_LH, OP_SW_SET_BH,
		OP_SW_RA, OP_SW_RB, OP_SW_WA, OP_SW_WA_PK, OP_SW_WB,
		OP_PART_INIT, OP_LO_RD, OP_HI_RD, OP_PUSH_R, OP_PUSH_L,
		OP_EM_RD, OP_EM_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic sp_zero;
		logic small_range;
		logic lo_stop;
		logic hi_stop;
		logic lo_ge_hi;
		logic em_last;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/median_of_three_quicksort.sv
// ----------------------------------------------------------------------------
// median_of_three_quicksort
// In-place quicksort of a loaded key set with median-of-three pivot choice.
// ----------------------------------------------------------------------------
// Usage: present key_in and final_in with start; a key is taken at each
// clock edge where start is high and busy is low, one key per cycle.
// Keys beyond MAX_KEYS are dropped, but a final mark still closes the set.
// After the final key, busy rises while the set is sorted: each scan step
// of the partition reads and checks one key, each swap reads both keys and
// writes them back, each popped range is set up with the middle pivot or
// the median of three and ends with the pushes, all bounded by the single
// read port of the key RAM. The sorted keys then leave one at a time on
// key_out, each valid for the one cycle that strobe is high, final_out on
// the last key; the receiver cannot hold them off. busy falls the cycle
// after the last. Configuration goes through the APB port; the user must
// write it only while busy is low, the block does not enforce it.
// Register 0 at address 0 is the small-range threshold, register 1 at
// address 4 selects signed compare. Reset returns to loading with an empty
// set, threshold 16 and unsigned compare; the RAMs need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module median_of_three_quicksort
	import mqs_pkg::*;
#(
	parameter int MAX_KEYS  = MAX_KEYS_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] key_in,
	input  wire logic        final_in,
	output logic             strobe,
	output logic      [31:0] key_out,
	output logic             final_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [THR_W-1:0] thr_q;
	logic             sgn_q;
	logic             cfg_wr;
	dp_cmd_t          cmd;
	dp_status_t       status;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			sgn_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_THR: thr_q <= pwdata[THR_W-1:0];
				REG_SGN: sgn_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			REG_THR: prdata = {{(32 - THR_W){1'b0}}, thr_q};
			REG_SGN: prdata = {31'd0, sgn_q};
			default: prdata = '0;
		endcase
	end

	mqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.final_in (final_in),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy),
		.strobe   (strobe)
	);

	mqs_datapath #(.MAX_KEYS(MAX_KEYS), .KEY_WIDTH(KEY_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.key_in    (key_in),
		.thr       (thr_q),
		.sgn       (sgn_q),
		.key_out   (key_out),
		.final_out (final_out)
	);

`include "median_of_three_quicksort_assert.svh"

	// results only come out while the block is busy
	`MQS_ASSERT_IMPL(a_strobe_busy, clk, arst_n, strobe, busy, "result outside busy")
	// a final key closes the set and starts sorting
	`MQS_ASSERT_NEXT(a_final_busy, clk, arst_n, start && !busy && final_in, busy,
		"final key did not start sort")
	// last result returns the block to loading
	`MQS_ASSERT_NEXT(a_last_idle, clk, arst_n, strobe && final_out, !busy,
		"busy after last result")
	// results never come back to back
	`MQS_ASSERT_NEXT(a_strobe_gap, clk, arst_n, strobe, !strobe, "back-to-back results")

endmodule
`default_nettype wire

FILE: rtl/mqs_ram.sv
// ----------------------------------------------------------------------------
// mqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/mqs_datapath.sv
// ----------------------------------------------------------------------------
// mqs_datapath
// Key store, range stack, index registers and comparators of the sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mqs_datapath
	import mqs_pkg::*;
#(
	parameter int MAX_KEYS  = MAX_KEYS_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	output dp_status_t            status,
	input  wire logic [31:0]      key_in,
	input  wire logic [THR_W-1:0] thr,
	input  wire logic             sgn,
	output logic      [31:0]      key_out,
	output logic                  final_out
);

	localparam int IW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int SW = IW + CW;
	localparam int TW = (CW > THR_W) ? CW : THR_W;
	localparam logic [CW-1:0] MAXC = CW'(MAX_KEYS);
	localparam logic [CW-1:0] ONE  = CW'(1);
	localparam logic [CW-1:0] TWO  = CW'(2);

	logic [CW-1:0]        count_q, sp_q, b_q, m_q, lo_q, hi_q, piv_q, sa_q, sb_q, oi_q;
	logic [KEY_WIDTH-1:0] ta_q, pk_q, kf_q, km_q;
	logic [CW-1:0]        last, mid, piv_med, size_r, size_l;
	logic [KEY_WIDTH-1:0] flip, k_rdata, k_wdata;
	logic [IW-1:0]        k_waddr, k_raddr, s_waddr, s_raddr;
	logic                 k_we, s_we, sp_room;
	logic [SW-1:0]        s_wdata, s_rdata;

	function automatic logic key_lt(input logic [KEY_WIDTH-1:0] a,
		input logic [KEY_WIDTH-1:0] b, input logic [KEY_WIDTH-1:0] f);
		key_lt = (a ^ f) < (b ^ f);
	endfunction

	// range geometry
	assign flip    = KEY_WIDTH'(sgn) << (KEY_WIDTH - 1);
	assign last    = b_q + m_q - ONE;
	assign mid     = b_q + (m_q >> 1);
	assign size_r  = last - hi_q;
	assign size_l  = hi_q - b_q;
	assign sp_room = sp_q < MAXC;

	// median of first, middle and last
	always_comb begin
		if (key_lt(kf_q, k_rdata, flip)) begin
			piv_med = key_lt(km_q, kf_q, flip) ? b_q :
				(key_lt(km_q, k_rdata, flip) ? mid : last);
		end else begin
			piv_med = key_lt(km_q, k_rdata, flip) ? last :
				(key_lt(km_q, kf_q, flip) ? mid : b_q);
		end
	end

	// status back to the controller
	assign status.sp_zero     = (sp_q == '0);
	assign status.small_range = TW'(m_q) <= TW'(thr);
	assign status.lo_stop     = !key_lt(k_rdata, pk_q, flip) || (lo_q >= last);
	assign status.hi_stop     = !key_lt(pk_q, k_rdata, flip) || (hi_q <= b_q);
	assign status.lo_ge_hi    = lo_q >= hi_q;
	assign status.em_last     = (oi_q + ONE) == count_q;

	assign key_out   = 32'(k_rdata);
	assign final_out = status.em_last;

	// memory port steering
	always_comb begin
		k_we    = 1'b0;
		k_waddr = '0;
		k_wdata = ta_q;
		k_raddr = '0;
		s_we    = 1'b0;
		s_waddr = sp_q[IW-1:0];
		s_wdata = '0;
		s_raddr = '0;
		unique case (cmd.op) inside
			OP_LOAD: begin
				k_we    = count_q < MAXC;
				k_waddr = count_q[IW-1:0];
				k_wdata = KEY_WIDTH'(key_in);
			end
			OP_INIT: begin
				s_we    = count_q >= TWO;
				s_waddr = '0;
				s_wdata = {IW'(0), count_q};
			end
			OP_POP_RD: s_raddr = IW'(sp_q - ONE);
			OP_MED_RB: k_raddr = b_q[IW-1:0];
			OP_MED_RM: k_raddr = mid[IW-1:0];
			OP_MED_RL: k_raddr = last[IW-1:0];
			OP_SW_RA:  k_raddr = sa_q[IW-1:0];
			OP_SW_RB:  k_raddr = sb_q[IW-1:0];
			OP_SW_WA, OP_SW_WA_PK: begin
				k_we    = 1'b1;
				k_waddr = sa_q[IW-1:0];
				k_wdata = k_rdata;
			end
			OP_SW_WB: begin
				k_we    = 1'b1;
				k_waddr = sb_q[IW-1:0];
				k_wdata = ta_q;
			end
			OP_LO_RD: k_raddr = IW'(lo_q + ONE);
			OP_HI_RD: k_raddr = IW'(hi_q - ONE);
			OP_PUSH_R: begin
				s_we    = sp_room && (size_r >= TWO);
				s_wdata = {IW'(hi_q + ONE), size_r};
			end
			OP_PUSH_L: begin
				s_we    = sp_room && (size_l >= TWO);
				s_wdata = {b_q[IW-1:0], size_l};
			end
			OP_EM_RD: k_raddr = oi_q[IW-1:0];
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sp_q    <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: if (count_q < MAXC) count_q <= count_q + ONE;
				OP_INIT: sp_q <= (count_q >= TWO) ? ONE : '0;
				OP_POP_RD: sp_q <= sp_q - ONE;
				OP_PUSH_R: if (sp_room && (size_r >= TWO)) sp_q <= sp_q + ONE;
				OP_PUSH_L: if (sp_room && (size_l >= TWO)) sp_q <= sp_q + ONE;
				OP_EM_OUT: if (status.em_last) count_q <= '0;
				default: ;
			endcase
		end
	end

	// index and key registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INIT:       oi_q <= '0;
			OP_POP_LATCH: begin
				b_q <= CW'(s_rdata[SW-1:CW]);
				m_q <= s_rdata[CW-1:0];
			end
			OP_PIV_MID:    piv_q <= mid;
			OP_MED_RM:     kf_q <= k_rdata;
			OP_MED_RL:     km_q <= k_rdata;
			OP_MED_SEL:    piv_q <= piv_med;
			OP_SW_SET_PIV: begin
				sa_q <= b_q;
				sb_q <= piv_q;
			end
			OP_SW_SET_LH: begin
				sa_q <= lo_q;
				sb_q <= hi_q;
			end
			OP_SW_SET_BH: begin
				sa_q <= b_q;
				sb_q <= hi_q;
			end
			OP_SW_RB:      ta_q <= k_rdata;
			OP_SW_WA_PK:   pk_q <= k_rdata;
			OP_PART_INIT: begin
				lo_q <= b_q;
				hi_q <= last + ONE;
			end
			OP_LO_RD:      lo_q <= lo_q + ONE;
			OP_HI_RD:      hi_q <= hi_q - ONE;
			OP_EM_OUT:     oi_q <= oi_q + ONE;
			default: ;
		endcase
	end

	mqs_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_KEYS)) u_key_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_waddr),
		.wdata (k_wdata),
		.raddr (k_raddr),
		.rdata (k_rdata)
	);

	mqs_ram #(.WIDTH(SW), .DEPTH(MAX_KEYS)) u_stack_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

endmodule
`default_nettype wire

FILE: rtl/mqs_ctrl.sv
// ----------------------------------------------------------------------------
// mqs_ctrl
// Sequencer for loading, quicksort partitioning and streaming out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mqs_ctrl
	import mqs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       final_in,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd,
	output logic            busy,
	output logic            strobe
);

	ctrl_state_t state_q, state_d;
	swap_kind_t  kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= SWK_PIV;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		unique case (state_q)
			S_IDLE:   if (start && final_in) state_d = S_INIT;
			S_INIT:   state_d = S_POP;
			S_POP:    state_d = status.sp_zero ? S_EMRD : S_POPW;
			S_POPW:   state_d = S_CHOOSE;
			S_CHOOSE: state_d = status.small_range ? S_PIVMID : S_MRB;
			S_PIVMID: state_d = S_SWPIV;
			S_MRB:    state_d = S_MRM;
			S_MRM:    state_d = S_MRL;
			S_MRL:    state_d = S_MSEL;
			S_MSEL:   state_d = S_SWPIV;
			S_SWPIV: begin
				state_d = S_SWRA;
				kind_d  = SWK_PIV;
			end
			S_SWLH: begin
				state_d = S_SWRA;
				kind_d  = SWK_PART;
			end
			S_SWBH: begin
				state_d = S_SWRA;
				kind_d  = SWK_FIN;
			end
			S_SWRA:   state_d = S_SWRB;
			S_SWRB:   state_d = S_SWWA;
			S_SWWA:   state_d = S_SWWB;
			S_SWWB: begin
				unique case (kind_q)
					SWK_PIV:  state_d = S_PINIT;
					SWK_PART: state_d = S_LORD;
					SWK_FIN:  state_d = S_PUSHR;
					default:  state_d = S_PUSHR;
				endcase
			end
			S_PINIT:  state_d = S_LORD;
			S_LORD:   state_d = S_LOCK;
			S_LOCK:   state_d = status.lo_stop ? S_HIRD : S_LORD;
			S_HIRD:   state_d = S_HICK;
			S_HICK: begin
				if (!status.hi_stop) begin
					state_d = S_HIRD;
				end else if (status.lo_ge_hi) begin
					state_d = S_SWBH;
				end else begin
					state_d = S_SWLH;
				end
			end
			S_PUSHR:  state_d = S_PUSHL;
			S_PUSHL:  state_d = S_POP;
			S_EMRD:   state_d = S_EMOUT;
			S_EMOUT:  state_d = status.em_last ? S_IDLE : S_EMRD;
			default:  state_d = S_IDLE;
		endcase
	end

	// datapath command per state
	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:   cmd.op = start ? OP_LOAD : OP_NONE;
			S_INIT:   cmd.op = OP_INIT;
			S_POP:    cmd.op = status.sp_zero ? OP_NONE : OP_POP_RD;
			S_POPW:   cmd.op = OP_POP_LATCH;
			S_PIVMID: cmd.op = OP_PIV_MID;
			S_MRB:    cmd.op = OP_MED_RB;
			S_MRM:    cmd.op = OP_MED_RM;
			S_MRL:    cmd.op = OP_MED_RL;
			S_MSEL:   cmd.op = OP_MED_SEL;
			S_SWPIV:  cmd.op = OP_SW_SET_PIV;
			S_SWLH:   cmd.op = OP_SW_SET_LH;
			S_SWBH:   cmd.op = OP_SW_SET_BH;
			S_SWRA:   cmd.op = OP_SW_RA;
			S_SWRB:   cmd.op = OP_SW_RB;
			S_SWWA:   cmd.op = (kind_q == SWK_PIV) ? OP_SW_WA_PK : OP_SW_WA;
			S_SWWB:   cmd.op = OP_SW_WB;
			S_PINIT:  cmd.op = OP_PART_INIT;
			S_LORD:   cmd.op = OP_LO_RD;
			S_HIRD:   cmd.op = OP_HI_RD;
			S_PUSHR:  cmd.op = OP_PUSH_R;
			S_PUSHL:  cmd.op = OP_PUSH_L;
			S_EMRD:   cmd.op = OP_EM_RD;
			S_EMOUT:  cmd.op = OP_EM_OUT;
			default:  cmd.op = OP_NONE;
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = (state_q == S_EMOUT);

endmodule
`default_nettype wire

FILE: test/tb_median_of_three_quicksort.sv
// ----------------------------------------------------------------------------
// tb_median_of_three_quicksort
// Loads key sets, some randomly paced, predicts the sorted stream with its
// own quicksort model and checks every emitted key and final mark in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// holds the expected sorted stream and the model of the loaded set
class sort_scoreboard;
	logic [31:0] set_keys[$];
	logic [31:0] sorted_q[$];
	logic        last_q[$];
	logic [6:0]  thr;
	logic        sgn;
	int          errors;

	function new();
		thr = 7'd16;
		sgn = 1'b0;
		errors = 0;
	endfunction

	function bit key_lt(logic [31:0] a, logic [31:0] b);
		logic [31:0] f;
		f = sgn ? 32'h8000_0000 : 32'h0;
		return (a ^ f) < (b ^ f);
	endfunction

	function int key_order(logic [31:0] a, logic [31:0] b);
		if (key_lt(a, b)) return -1;
		if (key_lt(b, a)) return 1;
		return 0;
	endfunction

	function void swap_keys(ref logic [31:0] k[64], input int a, input int b);
		logic [31:0] t;
		t = k[a]; k[a] = k[b]; k[b] = t;
	endfunction

	// quicksort with explicit range stack, pivot rule as the block does it
	function void sort_set();
		logic [31:0] k[64];
		int st[$];
		int sz[$];
		int n, b, m, last, mid, piv, lo, hi;
		n = set_keys.size();
		for (int i = 0; i < n; i++) k[i] = set_keys[i];
		if (n >= 2) begin st.push_back(0); sz.push_back(n); end
		while (st.size() > 0) begin
			b = st.pop_back(); m = sz.pop_back();
			last = b + m - 1; mid = b + m / 2;
			if (m <= thr) piv = mid;
			else if (key_order(k[b], k[last]) < 0)
				piv = key_order(k[mid], k[b]) < 0 ? b :
					(key_order(k[mid], k[last]) < 0 ? mid : last);
			else
				piv = key_order(k[mid], k[last]) < 0 ? last :
					(key_order(k[mid], k[b]) < 0 ? mid : b);
			swap_keys(k, b, piv);
			lo = b; hi = last + 1;
			forever begin
				do lo++; while (!(key_order(k[lo % 64], k[b]) >= 0 || lo >= last));
				do hi--; while (!(key_order(k[hi], k[b]) <= 0 || hi <= b));
				if (lo >= hi) break;
				swap_keys(k, lo, hi);
			end
			swap_keys(k, b, hi);
			if (last - hi >= 2) begin st.push_back(hi + 1); sz.push_back(last - hi); end
			if (hi - b >= 2) begin st.push_back(b); sz.push_back(hi - b); end
		end
		for (int i = 0; i < n; i++) begin
			sorted_q.push_back(k[i]);
			last_q.push_back(i == n - 1);
		end
		set_keys.delete();
	endfunction

	// note one accepted input transaction
	function void note_key(logic [31:0] key, logic fin);
		if (set_keys.size() < 64) set_keys.push_back(key);
		if (fin) sort_set();
	endfunction

	// compare one emitted transaction with the oldest expected key
	task check_key(logic [31:0] key, logic fin);
		logic [31:0] ek;
		logic        ef;
		if (sorted_q.size() == 0) begin
			report_err($sformatf("unexpected key %h", key));
			return;
		end
		ek = sorted_q.pop_front(); ef = last_q.pop_front();
		if (key !== ek) report_err($sformatf("key_out %h, want %h", key, ek));
		if (fin !== ef) report_err($sformatf("final_out %b, want %b", fin, ef));
	endtask

	task report_err(string s);
		$display("MISMATCH: %s", s);
		errors++;
	endtask
endclass

module tb_median_of_three_quicksort
	import mqs_pkg::*;
;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] key_in = '0;
	logic        final_in = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire         busy, strobe, final_out, pready;
	wire  [31:0] key_out, prdata;

	sort_scoreboard sb = new();

	median_of_three_quicksort u_dut (
		.clk, .arst_n, .start, .busy, .key_in, .final_in, .strobe, .key_out,
		.final_out, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: sample every strobe transaction
	always @(posedge clk)
		if (arst_n && strobe) sb.check_key(key_out, final_out);

	// register write through the apb port
	task automatic reg_write(logic idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_THR) sb.thr = val[6:0];
		else sb.sgn = val[0];
	endtask

	// offer one key, hold until accepted
	task automatic send_key(logic [31:0] key, logic fin);
		start <= 1'b1; key_in <= key; final_in <= fin;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_key(key, fin);
	endtask

	task automatic gap(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// random pacing: bursts with occasional gaps
	int burst_left = 0;
	task automatic paced_key(logic [31:0] key, logic fin);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 6));
		end
		burst_left--;
		send_key(key, fin);
	endtask

	function automatic logic [31:0] rand_key(int mode);
		case (mode)
			0: return $urandom_range(0, 7);
			1: return {$urandom_range(0, 1) ? 32'hFFFF_FFF8 : 32'h8000_0000}
				| $urandom_range(0, 7);
			default: return $urandom();
		endcase
	endfunction

	task automatic drain();
		start <= 1'b0;
		while (sb.sorted_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_set(int n);
		int mode;
		mode = $urandom_range(0, 2);
		for (int i = 0; i < n; i++) paced_key(rand_key(mode), i == n - 1);
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: single key, extremes, equal keys
		send_key(32'hFFFF_FFFF, 1'b1);
		drain();
		send_key(32'hFFFF_FFFF, 1'b0); send_key(32'h0, 1'b0);
		send_key(32'h8000_0000, 1'b0); send_key(32'h7FFF_FFFF, 1'b0);
		send_key(32'h7FFF_FFFF, 1'b1);
		drain();
		reg_write(REG_SGN, 32'h1);
		reg_write(REG_THR, 32'h0);
		send_key(32'hFFFF_FFFF, 1'b0); send_key(32'h0, 1'b0);
		send_key(32'h8000_0000, 1'b0); send_key(32'h7FFF_FFFF, 1'b0);
		send_key(32'h5, 1'b0); send_key(32'h5, 1'b1);
		drain();
		// store full: 70 keys, the extra ones dropped, final still closes
		reg_write(REG_THR, 32'd64);
		for (int i = 0; i < 70; i++) paced_key($urandom(), i == 69);
		drain();
		// random part across settings
		for (int p = 0; p < 3; p++) begin
			reg_write(REG_THR, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20));
			reg_write(REG_SGN, $urandom());
			random_set($urandom_range(1, 12));
		end
		if (sb.errors == 0 && sb.sorted_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

FILE: median_of_three_quicksort.f
+incdir+rtl
rtl/mqs_pkg.sv
rtl/mqs_ram.sv
rtl/mqs_datapath.sv
rtl/mqs_ctrl.sv
rtl/median_of_three_quicksort.sv
test/tb_median_of_three_quicksort.sv
